// ----- hw/rtl/tlvrc_pkg.sv -----
// Package for the TLV response checker: item types, register indexes and
// default sizes. No dependencies.

package tlvrc_pkg;

  // Offsets of PACKET_BYTES and beyond are not parsed.
  localparam int unsigned TLVRC_PACKET_BYTES = 512;

  // Result queue depth; one input item can push up to two results.
  localparam int unsigned TLVRC_OUT_DEPTH = 4;

  localparam int unsigned TLVRC_CFG_IDX_W = 2;

  typedef enum logic [TLVRC_CFG_IDX_W-1:0] {
    CFG_NONCE_LEN   = 2'd0,
    CFG_NONCE_VALUE = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    KIND_RECORD  = 1'b0,
    KIND_VERDICT = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    VERDICT_OK         = 2'd0,
    VERDICT_BAD_DATA   = 2'd1,
    VERDICT_MODULE_ERR = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       pkt_last;
  } in_item_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] rec_type;
    logic [7:0] rec_len;
    logic [8:0] rec_start;
    logic [1:0] verdict;
    logic [7:0] module_code;
    logic       out_last;
  } out_item_t;

  // Results of parsing one byte: an optional descriptor, then an optional verdict.
  typedef struct packed {
    logic      desc_vld;
    out_item_t desc;
    logic      verd_vld;
    out_item_t verd;
  } parse_res_t;

endpackage

// ----- hw/rtl/tlvrc_parser.sv -----
// Byte parser for the TLV response checker: packet state and result forming.
// Depends on tlvrc_pkg.

module tlvrc_parser #(
  parameter int unsigned PACKET_BYTES = tlvrc_pkg::TLVRC_PACKET_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  tlvrc_pkg::in_item_t   item_i,
  input  logic [3:0]            nonce_len_i,
  input  logic [63:0]           nonce_value_i,
  output tlvrc_pkg::parse_res_t res_o
);

  localparam int unsigned PosW = $clog2(PACKET_BYTES + 1);

  typedef enum logic [2:0] {
    PH_CODE  = 3'd0,
    PH_NLEN  = 3'd1,
    PH_NONCE = 3'd2,
    PH_TYPE  = 3'd3,
    PH_LEN   = 3'd4,
    PH_SKIP  = 3'd5,
    PH_DONE  = 3'd6
  } phase_e;

  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      skip_q, skip_d;
  logic            bad_q, bad_d;
  logic [7:0]      code_q, code_d;

  logic [7:0]  b;
  logic [3:0]  nidx;
  logic [7:0]  want;
  logic [31:0] start_wide;
  logic        desc_vld;
  logic        bad_pkt;

  assign b          = item_i.pkt_byte;
  assign nidx       = pos_q[3:0] - 4'd2;
  assign want       = nidx[3] ? 8'd0 : nonce_value_i[{nidx[2:0], 3'b000} +: 8];
  assign start_wide = 32'(pos_q) + 32'd1;

  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    type_d   = type_q;
    skip_d   = skip_q;
    bad_d    = bad_q;
    code_d   = code_q;
    desc_vld = 1'b0;
    if (pos_q >= PosW'(PACKET_BYTES)) begin
      bad_d = 1'b1;
    end else begin
      case (phase_q)
        PH_CODE: begin
          code_d  = b;
          phase_d = PH_NLEN;
        end
        PH_NLEN: begin
          if (b != {4'd0, nonce_len_i}) bad_d = 1'b1;
          if (nonce_len_i == 4'd0) begin
            phase_d = PH_TYPE;
          end else begin
            phase_d = PH_NONCE;
            skip_d  = {4'd0, nonce_len_i};
          end
        end
        PH_NONCE: begin
          if (b != want) bad_d = 1'b1;
          skip_d = skip_q - 8'd1;
          if (skip_d == 8'd0) phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          if (b == 8'd0) begin
            phase_d = PH_DONE;
          end else begin
            type_d  = b;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          desc_vld = !bad_q;
          if (b == 8'd0) begin
            phase_d = PH_TYPE;
          end else begin
            skip_d  = b;
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_d = skip_q - 8'd1;
          if (skip_d == 8'd0) phase_d = PH_TYPE;
        end
        default: begin
        end
      endcase
      pos_d = pos_q + PosW'(1);
    end
  end

  assign bad_pkt = bad_d || (pos_d < PosW'(3)) || (b != 8'd0) || (phase_d != PH_DONE);

  always_comb begin
    res_o                  = '0;
    res_o.desc_vld         = fire_i && desc_vld;
    res_o.desc.item_kind   = tlvrc_pkg::KIND_RECORD;
    res_o.desc.rec_type    = type_q;
    res_o.desc.rec_len     = b;
    res_o.desc.rec_start   = start_wide[8:0];
    res_o.verd_vld         = fire_i && item_i.pkt_last;
    res_o.verd.item_kind   = tlvrc_pkg::KIND_VERDICT;
    res_o.verd.module_code = code_d;
    res_o.verd.out_last    = 1'b1;
    if (bad_pkt) begin
      res_o.verd.verdict = tlvrc_pkg::VERDICT_BAD_DATA;
    end else if (code_d != 8'd0) begin
      res_o.verd.verdict = tlvrc_pkg::VERDICT_MODULE_ERR;
    end else begin
      res_o.verd.verdict = tlvrc_pkg::VERDICT_OK;
    end
  end

  // The verdict closes the packet and the state starts over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_CODE;
      type_q  <= '0;
      skip_q  <= '0;
      bad_q   <= 1'b0;
      code_q  <= '0;
    end else if (fire_i) begin
      if (item_i.pkt_last) begin
        pos_q   <= '0;
        phase_q <= PH_CODE;
        type_q  <= '0;
        skip_q  <= '0;
        bad_q   <= 1'b0;
        code_q  <= '0;
      end else begin
        pos_q   <= pos_d;
        phase_q <= phase_d;
        type_q  <= type_d;
        skip_q  <= skip_d;
        bad_q   <= bad_d;
        code_q  <= code_d;
      end
    end
  end

endmodule

// ----- hw/rtl/tlvrc_out_fifo.sv -----
// Result queue for the TLV response checker: takes up to two items a cycle,
// hands out one while out_stall_i is low. Depends on tlvrc_pkg.

module tlvrc_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tlvrc_pkg::parse_res_t push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tlvrc_pkg::out_item_t  out_item_o
);

  localparam int unsigned Depth = tlvrc_pkg::TLVRC_OUT_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tlvrc_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q, wr_next;
  logic [CntW-1:0] cnt_q;
  logic            pop;
  logic [1:0]      n_push;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  // Room for a full pair is judged on the registered count alone.
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign n_push      = {1'b0, push_i.desc_vld} + {1'b0, push_i.verd_vld};
  assign wr_next     = wr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.desc_vld) begin
      mem_q[wr_q] <= push_i.desc;
      if (push_i.verd_vld) mem_q[wr_next] <= push_i.verd;
    end else if (push_i.verd_vld) begin
      mem_q[wr_q] <= push_i.verd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(n_push);
      if (pop) rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + CntW'(n_push) - CntW'(pop);
    end
  end

endmodule

// ----- hw/rtl/tlv_response_checker.sv -----
// Top level of the TLV response checker: input register, byte parser and
// result queue. Depends on tlvrc_pkg, tlvrc_parser and tlvrc_out_fifo.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   in      | input     | in_valid_i/in_stall_o | in_item_i (byte, last mark)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (descriptor or verdict)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte per cycle is taken while the input does not stall; each byte waits in
// the input register and is parsed as it moves into the four-entry result queue.
// A byte that completes a record header on the last byte yields two items,
// a descriptor and a verdict, both pushed into the queue together.
// The input stalls while a byte waits in the input register and the queue
// holds more than two items.
// Reset clears the packet state and the registers; no clearing pass is needed.

module tlv_response_checker #(
  parameter int unsigned PACKET_BYTES = tlvrc_pkg::TLVRC_PACKET_BYTES
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  tlvrc_pkg::in_item_t                   in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output tlvrc_pkg::out_item_t                  out_item_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tlvrc_pkg::TLVRC_CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                           cfg_data_i
);

  logic                  s1_valid_q;
  tlvrc_pkg::in_item_t   s1_item_q;
  logic                  room;
  logic                  s1_fire;
  logic                  in_acc;
  logic [3:0]            nonce_len_q;
  logic [63:0]           nonce_value_q;
  tlvrc_pkg::parse_res_t res;

  assign cfg_ready_o = 1'b1;
  assign s1_fire     = s1_valid_q && room;
  assign in_stall_o  = s1_valid_q && !room;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonce_len_q   <= '0;
      nonce_value_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tlvrc_pkg::CFG_NONCE_LEN:   nonce_len_q   <= cfg_data_i[3:0];
        tlvrc_pkg::CFG_NONCE_VALUE: nonce_value_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc || (s1_valid_q && !room);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_item_q <= in_item_i;
  end

  tlvrc_parser #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .item_i       (s1_item_q),
    .nonce_len_i  (nonce_len_q),
    .nonce_value_i(nonce_value_q),
    .res_o        (res)
  );

  tlvrc_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for tlv_response_checker: streams response packets,
// predicts descriptors and verdicts, and compares every result item.
// Depends on tlvrc_pkg and the tlv_response_checker RTL.

module tb;

  localparam int unsigned PKT_MAX       = tlvrc_pkg::TLVRC_PACKET_BYTES;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned DIR_ROWS      = 25;

  typedef enum logic [2:0] {
    PS_CODE, PS_NLEN, PS_NONCE, PS_TYPE, PS_LEN, PS_SKIP, PS_DONE
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]          pkt_byte;
    logic                pkt_last;
    logic                known;
    tlvrc_pkg::verdict_e verd;
    logic [7:0]          code;
  } dir_row_t;

  logic                                  clk_i       = 1'b0;
  logic                                  rst_ni      = 1'b0;
  logic                                  in_valid_i  = 1'b0;
  logic                                  in_stall_o;
  tlvrc_pkg::in_item_t                   in_item_i   = '0;
  logic                                  out_valid_o;
  logic                                  out_stall_i = 1'b0;
  tlvrc_pkg::out_item_t                  out_item_o;
  logic                                  cfg_valid_i = 1'b0;
  logic                                  cfg_ready_o;
  logic [tlvrc_pkg::TLVRC_CFG_IDX_W-1:0] cfg_index_i = tlvrc_pkg::CFG_NONCE_LEN;
  logic [63:0]                           cfg_data_i  = '0;

  int unsigned cycle_count   = 0;
  int unsigned fail_count    = 0;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 55;

  // Shadow of the configuration and the packet parser.
  logic [3:0]   nlen_cfg  = '0;
  logic [63:0]  nonce_cfg = '0;
  int unsigned  pos_q     = 0;
  parse_phase_e phase_q   = PS_CODE;
  logic [7:0]   type_q    = '0;
  logic [7:0]   skip_q    = '0;
  logic         bad_q     = 1'b0;
  logic [7:0]   code_q    = '0;
  logic [7:0]   last_val  = '0;

  tlvrc_pkg::out_item_t expected_items [$];
  logic [7:0]           pkt_bytes [$];

  // Rows with a typed verdict were chosen so that they emit no descriptor.
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    // One-byte packet.
    '{8'h00, 1'b1, 1'b1, tlvrc_pkg::VERDICT_BAD_DATA, 8'h00},
    // Two-byte packet ending in a nonzero byte.
    '{8'hFF, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h80, 1'b1, 1'b1, tlvrc_pkg::VERDICT_BAD_DATA, 8'hFF},
    // Shortest good packet.
    '{8'h00, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h00, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h00, 1'b1, 1'b1, tlvrc_pkg::VERDICT_OK, 8'h00},
    // Good data with a nonzero result code.
    '{8'h5A, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h00, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h00, 1'b1, 1'b1, tlvrc_pkg::VERDICT_MODULE_ERR, 8'h5A},
    // One record, terminator, then ignored trailing bytes.
    '{8'h00, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h00, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h01, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h02, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'hAA, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h55, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h00, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'hFF, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h00, 1'b1, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    // Record header completes on the last byte: descriptor plus verdict.
    '{8'h00, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h00, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h07, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h00, 1'b1, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    // Nonce length byte disagrees with the register.
    '{8'h00, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h03, 1'b0, 1'b0, tlvrc_pkg::VERDICT_OK, 8'h00},
    '{8'h00, 1'b1, 1'b1, tlvrc_pkg::VERDICT_BAD_DATA, 8'h00}
  };

  tlv_response_checker DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  task automatic clear_packet();
    pos_q    = 0;
    phase_q  = PS_CODE;
    type_q   = '0;
    skip_q   = '0;
    bad_q    = 1'b0;
    code_q   = '0;
    last_val = '0;
  endtask

  // Advances the shadow parser by one byte and queues the items it causes.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int unsigned          idx;
    logic [7:0]           want;
    tlvrc_pkg::out_item_t res;
    last_val = b;
    if (pos_q >= PKT_MAX) begin
      bad_q = 1'b1;
    end else begin
      case (phase_q)
        PS_CODE: begin
          code_q  = b;
          phase_q = PS_NLEN;
        end
        PS_NLEN: begin
          if (b != {4'h0, nlen_cfg}) bad_q = 1'b1;
          if (nlen_cfg == 4'h0) begin
            phase_q = PS_TYPE;
          end else begin
            phase_q = PS_NONCE;
            skip_q  = {4'h0, nlen_cfg};
          end
        end
        PS_NONCE: begin
          // Nonce bytes past the eighth are expected to be zero.
          idx  = pos_q - 2;
          want = 8'h00;
          if (idx < 8) want = nonce_cfg[8*idx +: 8];
          if (b != want) bad_q = 1'b1;
          skip_q = skip_q - 8'd1;
          if (skip_q == 8'h00) phase_q = PS_TYPE;
        end
        PS_TYPE: begin
          if (b == 8'h00) begin
            phase_q = PS_DONE;
          end else begin
            type_q  = b;
            phase_q = PS_LEN;
          end
        end
        PS_LEN: begin
          if (!bad_q) begin
            res           = '0;
            res.item_kind = tlvrc_pkg::KIND_RECORD;
            res.rec_type  = type_q;
            res.rec_len   = b;
            res.rec_start = 9'(pos_q + 1);
            expected_items.push_back(res);
          end
          if (b == 8'h00) begin
            phase_q = PS_TYPE;
          end else begin
            skip_q  = b;
            phase_q = PS_SKIP;
          end
        end
        PS_SKIP: begin
          skip_q = skip_q - 8'd1;
          if (skip_q == 8'h00) phase_q = PS_TYPE;
        end
        default: ;
      endcase
      pos_q = pos_q + 1;
    end
    if (last) begin
      res           = '0;
      res.item_kind = tlvrc_pkg::KIND_VERDICT;
      if (bad_q || pos_q < 3 || last_val != 8'h00 || phase_q != PS_DONE) begin
        res.verdict = tlvrc_pkg::VERDICT_BAD_DATA;
      end else if (code_q != 8'h00) begin
        res.verdict = tlvrc_pkg::VERDICT_MODULE_ERR;
      end else begin
        res.verdict = tlvrc_pkg::VERDICT_OK;
      end
      res.module_code = code_q;
      res.out_last    = 1'b1;
      expected_items.push_back(res);
      clear_packet();
    end
  endtask

  task automatic check_result(input tlvrc_pkg::out_item_t got);
    tlvrc_pkg::out_item_t want;
    if (expected_items.size() == 0) begin
      $error("unexpected result item %h", got);
      fail_count++;
      return;
    end
    want = expected_items.pop_front();
    if (got.item_kind !== want.item_kind) begin
      $error("item_kind: expected %0d, actual %0d", want.item_kind, got.item_kind);
      fail_count++;
    end
    if (got.rec_type !== want.rec_type) begin
      $error("rec_type: expected %0d, actual %0d", want.rec_type, got.rec_type);
      fail_count++;
    end
    if (got.rec_len !== want.rec_len) begin
      $error("rec_len: expected %0d, actual %0d", want.rec_len, got.rec_len);
      fail_count++;
    end
    if (got.rec_start !== want.rec_start) begin
      $error("rec_start: expected %0d, actual %0d", want.rec_start, got.rec_start);
      fail_count++;
    end
    if (got.verdict !== want.verdict) begin
      $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
      fail_count++;
    end
    if (got.module_code !== want.module_code) begin
      $error("module_code: expected %0d, actual %0d", want.module_code, got.module_code);
      fail_count++;
    end
    if (got.out_last !== want.out_last) begin
      $error("out_last: expected %0d, actual %0d", want.out_last, got.out_last);
      fail_count++;
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{pkt_byte: b, pkt_last: last};
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(b, last);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      send_item(pkt_bytes[i], i == pkt_bytes.size() - 1);
    end
  endtask

  // Waits until every expected item has come out and the pipeline is empty.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_nonce(input logic [63:0] len_word, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= tlvrc_pkg::CFG_NONCE_LEN;
    cfg_data_i  <= len_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    nlen_cfg = len_word[3:0];
    cfg_index_i <= tlvrc_pkg::CFG_NONCE_VALUE;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    nonce_cfg = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed packets with random content; the rest are corrupted,
  // cut short or plain noise. A long packet runs past the parse window.
  task automatic make_packet(input logic long_pkt);
    int unsigned mode;
    int unsigned nrec;
    int unsigned len;
    int unsigned keep;
    pkt_bytes.delete();
    mode = $urandom_range(0, 99);
    pkt_bytes.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
    pkt_bytes.push_back({4'h0, nlen_cfg});
    for (int i = 0; i < nlen_cfg; i++) begin
      pkt_bytes.push_back(i < 8 ? nonce_cfg[8*i +: 8] : 8'h00);
    end
    nrec = long_pkt ? 1000 : $urandom_range(0, 4);
    for (int r = 0; r < nrec && pkt_bytes.size() < PKT_MAX + 20; r++) begin
      if (long_pkt) begin
        len = $urandom_range(20, 60);
      end else if ($urandom_range(0, 49) == 0) begin
        len = $urandom_range(0, 1) ? 255 : $urandom_range(0, 255);
      end else begin
        len = $urandom_range(0, 6);
      end
      pkt_bytes.push_back(8'($urandom_range(1, 255)));
      pkt_bytes.push_back(8'(len));
      repeat (len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    end
    pkt_bytes.push_back(8'h00);
    repeat ($urandom_range(0, 2)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) != 0) pkt_bytes[pkt_bytes.size() - 1] = 8'h00;
    if (!long_pkt) begin
      if (mode >= 70 && mode < 85) begin
        pkt_bytes[$urandom_range(0, pkt_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (mode >= 85 && mode < 93) begin
        keep = $urandom_range(1, pkt_bytes.size());
        while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
      end else if (mode >= 93) begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 12)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_item_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned          sent;
    tlvrc_pkg::out_item_t typed;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed packets run with the registers still at their reset values.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].pkt_byte, dir_rows[i].pkt_last);
      if (dir_rows[i].known) begin
        void'(expected_items.pop_back());
        typed             = '0;
        typed.item_kind   = tlvrc_pkg::KIND_VERDICT;
        typed.verdict     = dir_rows[i].verd;
        typed.module_code = dir_rows[i].code;
        typed.out_last    = 1'b1;
        expected_items.push_back(typed);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 55 : 0;
      recv_idle_pct = (ph < 2) ? 55 : (ph < 4) ? 31 : 0;
      drain_pipeline();
      case (ph)
        0: program_nonce(64'd8, '1);
        1: program_nonce(64'd15, {$urandom, $urandom});
        // Only the low four bits of the length word count.
        2: program_nonce(64'hFFFF_FFFF_FFFF_FFF3, {$urandom, $urandom});
        3: program_nonce(64'd0, 64'd0);
        4: program_nonce(64'd1, {$urandom, $urandom});
        default: program_nonce(64'd8, {$urandom, $urandom});
      endcase
      if (ph == NUM_PHASES - 1) begin
        make_packet(1'b1);
        send_packet();
      end
      sent = 0;
      while (sent < RANDOM_ITEMS / NUM_PHASES) begin
        make_packet(1'b0);
        send_packet();
        sent += pkt_bytes.size();
      end
    end

    in_valid_i <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && expected_items.size() != 0; n++) @(posedge clk_i);
    if (expected_items.size() != 0) begin
      $error("%0d expected result items never arrived", expected_items.size());
      fail_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
